@@ src/i2cblm_pkg.sv @@
// Package with the command codes, state types and result types of the I2C bit-level master.
`timescale 1ns / 1ps

package i2cblm_pkg;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [4:0] PHASE_ACK  = 5'd16;
    localparam logic [7:0] BYTE_MSB   = 8'h80;
    localparam logic [7:0] BYTE_LSB   = 8'h01;

    typedef enum logic [4:0] {
        CMD_IDLE  = 5'b00001,
        CMD_START = 5'b00010,
        CMD_STOP  = 5'b00100,
        CMD_WRITE = 5'b01000,
        CMD_READ  = 5'b10000
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [4:0] phase;
        logic [7:0] shift;
        logic       ack_hold;
        logic       scl;
        logic       sda;
        logic       last_ack;
        logic [7:0] rx_last;
    } t_state;

    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
    } t_result;

endpackage

@@ src/i2cblm_step.sv @@
// Next-state and result logic for one half-bit tick of the I2C bit-level master.
`timescale 1ns / 1ps

module i2cblm_step (
    input  i2cblm_pkg::t_state  i_state,
    input  logic [2:0]          i_opcode,
    input  logic [7:0]          i_tx_byte,
    input  logic                i_ack_to_send,
    input  logic                i_sda_in,
    output i2cblm_pkg::t_state  o_state,
    output i2cblm_pkg::t_result o_result
);

    i2cblm_pkg::t_state s;
    logic               busy;
    logic               done;

    always_comb begin
        s    = i_state;
        busy = 1'b0;
        done = 1'b0;

        if (s.cmd == i2cblm_pkg::CMD_IDLE) begin
            unique case (i_opcode)
                i2cblm_pkg::OP_START: begin
                    s.cmd   = i2cblm_pkg::CMD_START;
                    s.phase = '0;
                end
                i2cblm_pkg::OP_STOP: begin
                    s.cmd   = i2cblm_pkg::CMD_STOP;
                    s.phase = '0;
                end
                i2cblm_pkg::OP_WRITE: begin
                    s.cmd   = i2cblm_pkg::CMD_WRITE;
                    s.phase = '0;
                    s.shift = i_tx_byte;
                end
                i2cblm_pkg::OP_READ: begin
                    s.cmd      = i2cblm_pkg::CMD_READ;
                    s.phase    = '0;
                    s.shift    = '0;
                    s.ack_hold = i_ack_to_send;
                end
                default: begin
                end
            endcase
        end

        unique case (s.cmd)
            i2cblm_pkg::CMD_START: begin
                busy = 1'b1;
                if (s.phase == 5'd0) begin
                    s.sda = 1'b1;
                    s.scl = 1'b1;
                end else if (s.phase == 5'd1) begin
                    s.sda = 1'b0;
                end else begin
                    s.scl = 1'b0;
                    done  = 1'b1;
                end
            end
            i2cblm_pkg::CMD_STOP: begin
                busy = 1'b1;
                if (s.phase == 5'd0) begin
                    s.sda = 1'b0;
                    s.scl = 1'b1;
                end else begin
                    s.sda = 1'b1;
                    done  = 1'b1;
                end
            end
            i2cblm_pkg::CMD_WRITE: begin
                busy = 1'b1;
                if (s.phase < i2cblm_pkg::PHASE_ACK) begin
                    if (!s.phase[0]) begin
                        s.sda   = (s.shift & i2cblm_pkg::BYTE_MSB) != 8'h00;
                        s.shift = {s.shift[6:0], 1'b0};
                        s.scl   = 1'b1;
                    end else begin
                        s.scl = 1'b0;
                    end
                end else if (s.phase == i2cblm_pkg::PHASE_ACK) begin
                    s.sda      = 1'b1;
                    s.scl      = 1'b1;
                    s.last_ack = i_sda_in;
                end else begin
                    s.scl = 1'b0;
                    done  = 1'b1;
                end
            end
            i2cblm_pkg::CMD_READ: begin
                busy = 1'b1;
                if (s.phase < i2cblm_pkg::PHASE_ACK) begin
                    s.sda = 1'b1;
                    if (!s.phase[0]) begin
                        s.scl   = 1'b1;
                        s.shift = {s.shift[6:0], 1'b0}
                                  | ({7'd0, i_sda_in} & i2cblm_pkg::BYTE_LSB);
                    end else begin
                        s.scl = 1'b0;
                    end
                end else if (s.phase == i2cblm_pkg::PHASE_ACK) begin
                    s.sda = s.ack_hold;
                    s.scl = 1'b1;
                end else begin
                    s.scl     = 1'b0;
                    s.rx_last = s.shift;
                    done      = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (done) begin
            s.cmd   = i2cblm_pkg::CMD_IDLE;
            s.phase = '0;
        end else if (busy) begin
            s.phase = s.phase + 5'd1;
        end

        o_state              = s;
        o_result.scl_level   = s.scl;
        o_result.sda_release = s.sda;
        o_result.busy_res    = busy;
        o_result.done_res    = done;
        o_result.rx_byte     = s.rx_last;
        o_result.ack_seen    = s.last_ack;
    end

endmodule

@@ src/i2c_bit_level_master_unit.sv @@
// Top level of the I2C bit-level master: tick state register and result register.
// The result is registered and appears in the cycle after its tick is accepted.
// Throughput: one tick per cycle while no untaken result stalls the input; the tick logic
// is a single pass into the state register; a taken result frees the result register.
// Reset (synchronous, active low) sets the engine idle with SCL and SDA released high,
// clears the shift, acknowledge and received-byte state, and empties the result register.
`timescale 1ns / 1ps

module i2c_bit_level_master_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_opcode,
    input  logic [7:0] i_tx_byte,
    input  logic       i_ack_to_send,
    input  logic       i_sda_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_scl_level,
    output logic       o_sda_release,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_rx_byte,
    output logic       o_ack_seen
);

    i2cblm_pkg::t_state  r_state;
    i2cblm_pkg::t_state  n_state;
    i2cblm_pkg::t_result r_result;
    i2cblm_pkg::t_result n_result;
    logic                r_out_valid;
    logic                accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    i2cblm_step u_step (
        .i_state       (r_state),
        .i_opcode      (i_opcode),
        .i_tx_byte     (i_tx_byte),
        .i_ack_to_send (i_ack_to_send),
        .i_sda_in      (i_sda_in),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.cmd      <= i2cblm_pkg::CMD_IDLE;
            r_state.phase    <= '0;
            r_state.shift    <= '0;
            r_state.ack_hold <= 1'b0;
            r_state.scl      <= 1'b1;
            r_state.sda      <= 1'b1;
            r_state.last_ack <= 1'b0;
            r_state.rx_last  <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_scl_level   = r_result.scl_level;
    assign o_sda_release = r_result.sda_release;
    assign o_busy_res    = r_result.busy_res;
    assign o_done_res    = r_result.done_res;
    assign o_rx_byte     = r_result.rx_byte;
    assign o_ack_seen    = r_result.ack_seen;

endmodule

@@ src/i2cblm_checker.sv @@
// Port-level checker for the I2C bit-level master and its bind to the top level.
`timescale 1ns / 1ps

module i2cblm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_scl_level,
    input logic       o_sda_release,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic [7:0] o_rx_byte
);

    logic       r_prev_valid;
    logic       r_prev_busy;
    logic       r_prev_done;
    logic       r_prev_scl;
    logic       r_prev_sda;
    logic [7:0] r_prev_rx;

    // The last delivered result is kept so that each new one can be compared with it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            r_prev_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            r_prev_busy <= o_busy_res;
            r_prev_done <= o_done_res;
            r_prev_scl  <= o_scl_level;
            r_prev_sda  <= o_sda_release;
            r_prev_rx   <= o_rx_byte;
        end
    end

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> o_busy_res)
        else $error("done reported without busy");

    a_cmd_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_prev_valid && r_prev_busy && !r_prev_done |-> o_busy_res)
        else $error("command ended without a done transaction");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_prev_valid && !o_busy_res |->
            o_scl_level == r_prev_scl && o_sda_release == r_prev_sda)
        else $error("bus lines changed on an idle tick");

    a_rx_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_prev_valid && !o_done_res |-> o_rx_byte == r_prev_rx)
        else $error("received byte changed outside a done transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_rx_byte)
            && $stable(o_busy_res) && $stable(o_done_res))
        else $error("stalled result changed");

endmodule

bind i2c_bit_level_master_unit i2cblm_checker u_i2cblm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_scl_level   (o_scl_level),
    .o_sda_release (o_sda_release),
    .o_busy_res    (o_busy_res),
    .o_done_res    (o_done_res),
    .o_rx_byte     (o_rx_byte)
);
